>>> hw/rtl/jqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jqd_pkg;

    // Default sizes
    localparam int JQD_FIBER_SLOTS = 128;
    localparam int JQD_QUEUE_DEPTH = 64;

    // Field widths
    localparam int JQD_TOKEN_W   = 32;
    localparam int JQD_COUNTER_W = 16;
    localparam int JQD_FIBER_W   = 7;
    localparam int JQD_ENTRY_W   = 2 * JQD_TOKEN_W + JQD_COUNTER_W;

    // Slot map is searched in groups of this many slots
    localparam int JQD_GROUP_W   = 32;
    localparam int JQD_GROUP_IW  = 5;

    // Request kinds
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_FREE = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NO_FIBER = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed
    {
        logic [1:0]               mode;
        logic [JQD_TOKEN_W-1:0]   job_func;
        logic [JQD_TOKEN_W-1:0]   job_param;
        logic [JQD_COUNTER_W-1:0] job_counter;
        logic [JQD_FIBER_W-1:0]   fiber_index;
    } req_t;

    typedef struct packed
    {
        logic [1:0]               status;
        logic [JQD_TOKEN_W-1:0]   out_func;
        logic [JQD_TOKEN_W-1:0]   out_param;
        logic [JQD_COUNTER_W-1:0] out_counter;
        logic [JQD_FIBER_W-1:0]   out_fiber;
    } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/jqd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module jqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/job_queue_fiber_slot_dispatch.sv
`timescale 1ns / 1ps
`default_nettype none

// Job dispatcher: a FIFO of jobs in one synchronous RAM plus a map of fiber slots in
// flip-flops that reset clears at once (no clearing pass). Each request runs as follows:
// in the accept cycle the FIFO head is read from the RAM and the first slot group with a
// free slot is found; in the ST_EXEC state the free slot inside that group is picked, the
// queue and slot map are updated and the result beat is loaded into the output register.
// The next request is accepted as soon as the result is in that register; a request waits
// in ST_EXEC only while an earlier result still sits untaken in the register.

module job_queue_fiber_slot_dispatch #(
    parameter int FIBER_SLOTS = jqd_pkg::JQD_FIBER_SLOTS,
    parameter int QUEUE_DEPTH = jqd_pkg::JQD_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire jqd_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output jqd_pkg::rsp_t      rsp
);

    import jqd_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int NGRP   = (FIBER_SLOTS + JQD_GROUP_W - 1) / JQD_GROUP_W;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD    = NGRP * JQD_GROUP_W;
    localparam int SLOT_W = GRP_W + JQD_GROUP_IW;

    state_t                   state_reg, state_next;
    req_t                     req_reg;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [FIBER_SLOTS-1:0]   taken_reg, taken_next;
    logic [GRP_W-1:0]         grp_reg;
    logic                     grp_any_reg;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    logic                     accept;
    logic                     finish;
    logic [PAD-1:0]           taken_pad;
    logic [NGRP-1:0]          grp_full;
    logic [GRP_W-1:0]         grp_idx;
    logic                     grp_any;
    logic [JQD_GROUP_W-1:0]   grp_word;
    logic [JQD_GROUP_IW-1:0]  bit_idx;
    logic [SLOT_W-1:0]        slot_num;
    logic                     q_empty;
    logic                     q_full;
    logic                     wr_en;
    logic                     rd_en;
    logic [JQD_ENTRY_W-1:0]   wr_data;
    logic [JQD_ENTRY_W-1:0]   rd_data;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Job FIFO storage
    assign rd_en   = accept && (req.mode == MODE_POP);
    assign wr_en   = finish && (req_reg.mode == MODE_PUSH) && !q_full;
    assign wr_data = {req_reg.job_func, req_reg.job_param, req_reg.job_counter};

    jqd_ram #(
        .WIDTH (JQD_ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // Pad the slot map with taken slots up to whole groups
    always_comb
    begin
        taken_pad                  = '1;
        taken_pad[FIBER_SLOTS-1:0] = taken_reg;
    end

    // First search level: lowest group that still has a free slot
    always_comb
    begin
        grp_idx = '0;
        grp_any = 1'b0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_full[g] = &taken_pad[g*JQD_GROUP_W +: JQD_GROUP_W];
        end
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (!grp_full[g])
            begin
                grp_idx = GRP_W'(g);
                grp_any = 1'b1;
            end
        end
    end

    // Second search level: lowest free slot inside the chosen group
    always_comb
    begin
        grp_word = taken_pad[JQD_GROUP_W-1:0];
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_reg == GRP_W'(g))
            begin
                grp_word = taken_pad[g*JQD_GROUP_W +: JQD_GROUP_W];
            end
        end
        bit_idx = '0;
        for (int b = JQD_GROUP_W - 1; b >= 0; b--)
        begin
            if (!grp_word[b])
            begin
                bit_idx = JQD_GROUP_IW'(b);
            end
        end
    end

    assign slot_num = {grp_reg, bit_idx};

    // Sequencer: finish the request, update state, load the result register
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        taken_next     = taken_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        finish         = 1'b0;

        // drop the result once it is taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    finish         = 1'b1;
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.status = STAT_OK;
                    case (req_reg.mode)
                        MODE_PUSH:
                        begin
                            if (q_full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (q_empty)
                            begin
                                rsp_next.status = STAT_EMPTY;
                            end
                            else if (!grp_any_reg)
                            begin
                                rsp_next.status = STAT_NO_FIBER;
                            end
                            else
                            begin
                                for (int i = 0; i < FIBER_SLOTS; i++)
                                begin
                                    if (32'(slot_num) == i)
                                    begin
                                        taken_next[i] = 1'b1;
                                    end
                                end
                                rsp_next.out_func    = rd_data[JQD_ENTRY_W-1 -: JQD_TOKEN_W];
                                rsp_next.out_param   =
                                    rd_data[JQD_COUNTER_W +: JQD_TOKEN_W];
                                rsp_next.out_counter = rd_data[JQD_COUNTER_W-1:0];
                                rsp_next.out_fiber   = JQD_FIBER_W'(slot_num);
                                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_FREE:
                        begin
                            // a slot number past the map matches nothing
                            for (int i = 0; i < FIBER_SLOTS; i++)
                            begin
                                if (32'(req_reg.fiber_index) == i)
                                begin
                                    taken_next[i] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            taken_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            taken_reg     <= taken_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: hold the request, the first search level and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= req;
            grp_reg     <= grp_idx;
            grp_any_reg <= grp_any;
        end
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/jqd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jqd_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire jqd_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire jqd_pkg::rsp_t rsp
);

    import jqd_pkg::*;

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Refused or empty results carry no job
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_OK) |->
            (rsp.out_func == '0) && (rsp.out_param == '0) &&
            (rsp.out_counter == '0) && (rsp.out_fiber == '0))
        else $error("failed result carries payload");

    // An accepted request keeps the sequencer busy for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

    // A new result appears only after a busy cycle
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in progress");

endmodule

bind job_queue_fiber_slot_dispatch jqd_checker u_jqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
